>>> hdl/mip_chain_subresource_address_assert.svh
// assertion macros used by the checker file
`ifndef MIP_CHAIN_SUBRESOURCE_ADDRESS_ASSERT_SVH
`define MIP_CHAIN_SUBRESOURCE_ADDRESS_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MCSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcsa assertion failed");

// next-cycle implication, disabled while in reset
`define MCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcsa assertion failed");

`endif

>>> hdl/mcsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsa_pkg
// shared types and constants of the mip chain subresource address unit
// ----------------------------------------------------------------------------
package mcsa_pkg;

    localparam int unsigned MAX_LEVELS_DEF = 15;
    localparam int unsigned CFG_INDEX_W    = 3;
    localparam int unsigned CFG_DATA_W     = 15;
    // aligned row pitch and slice pitch never need more than these
    localparam int unsigned ROW_W          = 26;
    localparam int unsigned SLICE_W        = 41;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_WIDTH     = 3'd0,
        REG_BASE_HEIGHT    = 3'd1,
        REG_BASE_DEPTH     = 3'd2,
        REG_MIP_COUNT      = 3'd3,
        REG_VOLUME_MODE    = 3'd4,
        REG_TEXEL_BYTES    = 3'd5,
        REG_SAMPLE_COUNT   = 3'd6,
        REG_ROW_ALIGN_LOG2 = 3'd7
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROW_TB,
        ST_ROW_SC,
        ST_ROW_ALIGN,
        ST_SLICE_MUL,
        ST_SLICE_LOAD,
        ST_SIZE_LO,
        ST_SIZE_HI,
        ST_SIZE_ADD,
        ST_OFF_Z_LO,
        ST_OFF_Z_HI,
        ST_OFF_Y,
        ST_OFF_X,
        ST_SPAN_D_LO,
        ST_SPAN_D_HI,
        ST_SPAN_H,
        ST_SPAN_W,
        ST_SPAN_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MUL_HOLD,
        MUL_W_TB,
        MUL_PROD_SC,
        MUL_ROW_H,
        MUL_SLO_CNT,
        MUL_SHI_CNT,
        MUL_SLO_Z,
        MUL_SHI_Z,
        MUL_ROW_Y,
        MUL_X_TB,
        MUL_SLO_D,
        MUL_SHI_D,
        MUL_ROW_H1,
        MUL_EW_TB
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_OFF_LO,
        ACC_OFF_HI,
        ACC_SPAN_LO,
        ACC_SPAN_HI
    } acc_op_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    row_load;
        logic    slice_load;
        acc_op_t acc_op;
        logic    m_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic lvl_bad;
        logic m_done;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/mcsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsa_ctrl
// sequencer: walks the earlier mip levels, then the region terms
// ----------------------------------------------------------------------------
module mcsa_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  mcsa_pkg::stat_t stat,
    output mcsa_pkg::cmd_t  cmd
);

    mcsa_pkg::state_t state_reg;
    mcsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcsa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mcsa_pkg::ST_CHECK;
                end
            end
            mcsa_pkg::ST_CHECK:
            begin
                state_next = stat.lvl_bad ? mcsa_pkg::ST_DONE : mcsa_pkg::ST_ROW_TB;
            end
            mcsa_pkg::ST_ROW_TB:     state_next = mcsa_pkg::ST_ROW_SC;
            mcsa_pkg::ST_ROW_SC:     state_next = mcsa_pkg::ST_ROW_ALIGN;
            mcsa_pkg::ST_ROW_ALIGN:  state_next = mcsa_pkg::ST_SLICE_MUL;
            mcsa_pkg::ST_SLICE_MUL:  state_next = mcsa_pkg::ST_SLICE_LOAD;
            mcsa_pkg::ST_SLICE_LOAD:
            begin
                // pitches of the requested level are ready once the walk reaches it
                state_next = stat.m_done ? mcsa_pkg::ST_OFF_Z_LO : mcsa_pkg::ST_SIZE_LO;
            end
            mcsa_pkg::ST_SIZE_LO:    state_next = mcsa_pkg::ST_SIZE_HI;
            mcsa_pkg::ST_SIZE_HI:    state_next = mcsa_pkg::ST_SIZE_ADD;
            mcsa_pkg::ST_SIZE_ADD:   state_next = mcsa_pkg::ST_ROW_TB;
            mcsa_pkg::ST_OFF_Z_LO:   state_next = mcsa_pkg::ST_OFF_Z_HI;
            mcsa_pkg::ST_OFF_Z_HI:   state_next = mcsa_pkg::ST_OFF_Y;
            mcsa_pkg::ST_OFF_Y:      state_next = mcsa_pkg::ST_OFF_X;
            mcsa_pkg::ST_OFF_X:      state_next = mcsa_pkg::ST_SPAN_D_LO;
            mcsa_pkg::ST_SPAN_D_LO:  state_next = mcsa_pkg::ST_SPAN_D_HI;
            mcsa_pkg::ST_SPAN_D_HI:  state_next = mcsa_pkg::ST_SPAN_H;
            mcsa_pkg::ST_SPAN_H:     state_next = mcsa_pkg::ST_SPAN_W;
            mcsa_pkg::ST_SPAN_W:     state_next = mcsa_pkg::ST_SPAN_FIN;
            mcsa_pkg::ST_SPAN_FIN:   state_next = mcsa_pkg::ST_DONE;
            mcsa_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = mcsa_pkg::ST_IDLE;
                end
            end
            default:                 state_next = mcsa_pkg::ST_IDLE;
        endcase
    end

    // each state from ROW_TB to SPAN_FIN starts a multiply, consumes the product of the state before, or both
    always_comb
    begin
        cmd          = '0;
        cmd.mul_op   = mcsa_pkg::MUL_HOLD;
        cmd.acc_op   = mcsa_pkg::ACC_NONE;
        in_stall     = 1'b1;
        case (state_reg)
            mcsa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            mcsa_pkg::ST_ROW_TB:     cmd.mul_op = mcsa_pkg::MUL_W_TB;
            mcsa_pkg::ST_ROW_SC:     cmd.mul_op = mcsa_pkg::MUL_PROD_SC;
            mcsa_pkg::ST_ROW_ALIGN:  cmd.row_load = 1'b1;
            mcsa_pkg::ST_SLICE_MUL:  cmd.mul_op = mcsa_pkg::MUL_ROW_H;
            mcsa_pkg::ST_SLICE_LOAD: cmd.slice_load = 1'b1;
            mcsa_pkg::ST_SIZE_LO:    cmd.mul_op = mcsa_pkg::MUL_SLO_CNT;
            mcsa_pkg::ST_SIZE_HI:
            begin
                cmd.acc_op = mcsa_pkg::ACC_OFF_LO;
                cmd.mul_op = mcsa_pkg::MUL_SHI_CNT;
            end
            mcsa_pkg::ST_SIZE_ADD:
            begin
                cmd.acc_op = mcsa_pkg::ACC_OFF_HI;
                cmd.m_inc  = 1'b1;
            end
            mcsa_pkg::ST_OFF_Z_LO:   cmd.mul_op = mcsa_pkg::MUL_SLO_Z;
            mcsa_pkg::ST_OFF_Z_HI:
            begin
                cmd.acc_op = mcsa_pkg::ACC_OFF_LO;
                cmd.mul_op = mcsa_pkg::MUL_SHI_Z;
            end
            mcsa_pkg::ST_OFF_Y:
            begin
                cmd.acc_op = mcsa_pkg::ACC_OFF_HI;
                cmd.mul_op = mcsa_pkg::MUL_ROW_Y;
            end
            mcsa_pkg::ST_OFF_X:
            begin
                cmd.acc_op = mcsa_pkg::ACC_OFF_LO;
                cmd.mul_op = mcsa_pkg::MUL_X_TB;
            end
            mcsa_pkg::ST_SPAN_D_LO:
            begin
                cmd.acc_op = mcsa_pkg::ACC_OFF_LO;
                cmd.mul_op = mcsa_pkg::MUL_SLO_D;
            end
            mcsa_pkg::ST_SPAN_D_HI:
            begin
                cmd.acc_op = mcsa_pkg::ACC_SPAN_LO;
                cmd.mul_op = mcsa_pkg::MUL_SHI_D;
            end
            mcsa_pkg::ST_SPAN_H:
            begin
                cmd.acc_op = mcsa_pkg::ACC_SPAN_HI;
                cmd.mul_op = mcsa_pkg::MUL_ROW_H1;
            end
            mcsa_pkg::ST_SPAN_W:
            begin
                cmd.acc_op = mcsa_pkg::ACC_SPAN_LO;
                cmd.mul_op = mcsa_pkg::MUL_EW_TB;
            end
            mcsa_pkg::ST_SPAN_FIN:   cmd.acc_op = mcsa_pkg::ACC_SPAN_LO;
            mcsa_pkg::ST_DONE:       cmd.out_load = stat.out_free;
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/mcsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsa_datapath
// configuration registers, shared 32x16 multiplier, saturating accumulators
// and the output word register
// ----------------------------------------------------------------------------
module mcsa_datapath
#(
    parameter int unsigned MAX_LEVELS = mcsa_pkg::MAX_LEVELS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mcsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcsa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [3:0]                          level,
    input  logic [13:0]                         origin_x,
    input  logic [13:0]                         origin_y,
    input  logic [10:0]                         origin_z,
    input  logic [14:0]                         extent_w,
    input  logic [14:0]                         extent_h,
    input  logic [11:0]                         extent_d,
    input  mcsa_pkg::cmd_t                      cmd,
    output mcsa_pkg::stat_t                     stat,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [47:0]                         byte_offset,
    output logic [47:0]                         span_bytes,
    output logic [31:0]                         row_pitch,
    output logic [47:0]                         slice_pitch,
    output logic                                error
);

    localparam int unsigned RW = mcsa_pkg::ROW_W;
    localparam int unsigned SW = mcsa_pkg::SLICE_W;
    localparam logic [47:0] CAP48 = {48{1'b1}};

    function automatic logic [14:0] dim_at(input logic [14:0] base, input logic [3:0] lvl);
        logic [14:0] b;
        logic [14:0] s;
        b = (base == 15'd0) ? 15'd1 : base;
        s = b >> lvl;
        return (s == 15'd0) ? 15'd1 : s;
    endfunction

    // configuration
    logic [14:0] base_width_reg;
    logic [14:0] base_height_reg;
    logic [11:0] base_depth_reg;
    logic [3:0]  mip_count_reg;
    logic        volume_mode_reg;
    logic [4:0]  texel_bytes_reg;
    logic [4:0]  sample_count_reg;
    logic [3:0]  row_align_reg;

    // captured request
    logic [3:0]  lvl_reg;
    logic [13:0] ox_reg;
    logic [13:0] oy_reg;
    logic [10:0] oz_reg;
    logic [14:0] ew_reg;
    logic [14:0] eh_m1_reg;
    logic [11:0] ed_m1_reg;

    // working registers
    logic [3:0]    m_reg;
    logic [47:0]   prod_reg;
    logic [47:0]   prod_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [SW-1:0] slice_reg;
    logic [47:0]   off_reg;
    logic [47:0]   off_next;
    logic [47:0]   span_reg;
    logic [47:0]   span_next;
    logic          ovf_reg;
    logic          ovf_next;

    logic          out_valid_reg;
    logic [47:0]   out_off_reg;
    logic [47:0]   out_span_reg;
    logic [31:0]   out_row_reg;
    logic [47:0]   out_slice_reg;
    logic          out_err_reg;

    logic [14:0]   dim_w;
    logic [14:0]   dim_h;
    logic [11:0]   layer_cnt;
    logic [14:0]   depth_dim;
    logic [31:0]   mul_a;
    logic [15:0]   mul_b;
    logic [RW-1:0] align_mask;
    logic [53:0]   acc_add;
    logic [53:0]   acc_sum;
    logic [47:0]   acc_base;
    logic          lvl_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_width_reg   <= 15'd1;
            base_height_reg  <= 15'd1;
            base_depth_reg   <= 12'd1;
            mip_count_reg    <= 4'd1;
            volume_mode_reg  <= 1'b0;
            texel_bytes_reg  <= 5'd4;
            sample_count_reg <= 5'd1;
            row_align_reg    <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mcsa_pkg::REG_BASE_WIDTH:     base_width_reg   <= cfg_data[14:0];
                mcsa_pkg::REG_BASE_HEIGHT:    base_height_reg  <= cfg_data[14:0];
                mcsa_pkg::REG_BASE_DEPTH:     base_depth_reg   <= cfg_data[11:0];
                mcsa_pkg::REG_MIP_COUNT:      mip_count_reg    <= cfg_data[3:0];
                mcsa_pkg::REG_VOLUME_MODE:    volume_mode_reg  <= cfg_data[0];
                mcsa_pkg::REG_TEXEL_BYTES:    texel_bytes_reg  <= cfg_data[4:0];
                mcsa_pkg::REG_SAMPLE_COUNT:   sample_count_reg <= cfg_data[4:0];
                mcsa_pkg::REG_ROW_ALIGN_LOG2: row_align_reg    <= cfg_data[3:0];
                default:                      row_align_reg    <= row_align_reg;
            endcase
        end
    end

    // level dimensions at the walk position; a layered texture keeps the base depth as its layer count
    always_comb
    begin
        dim_w     = dim_at(base_width_reg, m_reg);
        dim_h     = dim_at(base_height_reg, m_reg);
        depth_dim = dim_at({3'd0, base_depth_reg}, m_reg);
        if (volume_mode_reg)
        begin
            layer_cnt = depth_dim[11:0];
        end
        else
        begin
            layer_cnt = (base_depth_reg == 12'd0) ? 12'd1 : base_depth_reg;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 16'd0;
        case (cmd.mul_op)
            mcsa_pkg::MUL_W_TB:
            begin
                mul_a = 32'(dim_w);
                mul_b = 16'(texel_bytes_reg);
            end
            mcsa_pkg::MUL_PROD_SC:
            begin
                mul_a = {12'd0, prod_reg[19:0]};
                mul_b = 16'(sample_count_reg);
            end
            mcsa_pkg::MUL_ROW_H:
            begin
                mul_a = 32'(row_reg);
                mul_b = 16'(dim_h);
            end
            mcsa_pkg::MUL_SLO_CNT:
            begin
                mul_a = slice_reg[31:0];
                mul_b = 16'(layer_cnt);
            end
            mcsa_pkg::MUL_SHI_CNT:
            begin
                mul_a = 32'(slice_reg[SW-1:32]);
                mul_b = 16'(layer_cnt);
            end
            mcsa_pkg::MUL_SLO_Z:
            begin
                mul_a = slice_reg[31:0];
                mul_b = 16'(oz_reg);
            end
            mcsa_pkg::MUL_SHI_Z:
            begin
                mul_a = 32'(slice_reg[SW-1:32]);
                mul_b = 16'(oz_reg);
            end
            mcsa_pkg::MUL_ROW_Y:
            begin
                mul_a = 32'(row_reg);
                mul_b = 16'(oy_reg);
            end
            mcsa_pkg::MUL_X_TB:
            begin
                mul_a = 32'(ox_reg);
                mul_b = 16'(texel_bytes_reg);
            end
            mcsa_pkg::MUL_SLO_D:
            begin
                mul_a = slice_reg[31:0];
                mul_b = 16'(ed_m1_reg);
            end
            mcsa_pkg::MUL_SHI_D:
            begin
                mul_a = 32'(slice_reg[SW-1:32]);
                mul_b = 16'(ed_m1_reg);
            end
            mcsa_pkg::MUL_ROW_H1:
            begin
                mul_a = 32'(row_reg);
                mul_b = 16'(eh_m1_reg);
            end
            mcsa_pkg::MUL_EW_TB:
            begin
                mul_a = 32'(ew_reg);
                mul_b = 16'(texel_bytes_reg);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.mul_op == mcsa_pkg::MUL_HOLD)
        begin
            prod_next = prod_reg;
        end
        else
        begin
            prod_next = {16'd0, mul_a} * {32'd0, mul_b};
        end
    end

    // row pitch rounded up to the alignment
    always_comb
    begin
        align_mask = RW'((32'd1 << row_align_reg) - 32'd1);
        row_next   = (prod_reg[RW-1:0] + align_mask) & ~align_mask;
    end

    // saturating accumulate; the upper partial product is at most 22 bits wide
    always_comb
    begin
        if (cmd.acc_op == mcsa_pkg::ACC_OFF_HI || cmd.acc_op == mcsa_pkg::ACC_SPAN_HI)
        begin
            acc_add = {prod_reg[21:0], 32'd0};
        end
        else
        begin
            acc_add = {6'd0, prod_reg};
        end
        if (cmd.acc_op == mcsa_pkg::ACC_SPAN_LO || cmd.acc_op == mcsa_pkg::ACC_SPAN_HI)
        begin
            acc_base = span_reg;
        end
        else
        begin
            acc_base = off_reg;
        end
        acc_sum   = {6'd0, acc_base} + acc_add;
        off_next  = off_reg;
        span_next = span_reg;
        ovf_next  = ovf_reg;
        if (cmd.acc_op != mcsa_pkg::ACC_NONE)
        begin
            if (acc_sum > {6'd0, CAP48})
            begin
                ovf_next = 1'b1;
                if (acc_base == span_reg &&
                    (cmd.acc_op == mcsa_pkg::ACC_SPAN_LO ||
                     cmd.acc_op == mcsa_pkg::ACC_SPAN_HI))
                begin
                    span_next = CAP48;
                end
                else
                begin
                    off_next = CAP48;
                end
            end
            else if (cmd.acc_op == mcsa_pkg::ACC_SPAN_LO ||
                     cmd.acc_op == mcsa_pkg::ACC_SPAN_HI)
            begin
                span_next = acc_sum[47:0];
            end
            else
            begin
                off_next = acc_sum[47:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.row_load)
        begin
            row_reg <= row_next;
        end
        if (cmd.slice_load)
        begin
            slice_reg <= prod_reg[SW-1:0];
        end
        if (cmd.load)
        begin
            lvl_reg   <= level;
            ox_reg    <= origin_x;
            oy_reg    <= origin_y;
            oz_reg    <= origin_z;
            ew_reg    <= (extent_w == 15'd0) ? 15'd1 : extent_w;
            eh_m1_reg <= (extent_h == 15'd0) ? 15'd0 : extent_h - 15'd1;
            ed_m1_reg <= (extent_d == 12'd0) ? 12'd0 : extent_d - 12'd1;
            off_reg   <= 48'd0;
            span_reg  <= 48'd0;
        end
        else
        begin
            off_reg   <= off_next;
            span_reg  <= span_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg   <= 4'd0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_reg   <= 4'd0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            ovf_reg <= ovf_next;
            if (cmd.m_inc)
            begin
                m_reg <= m_reg + 4'd1;
            end
        end
    end

    assign lvl_bad = ({1'b0, lvl_reg} >= 5'(MAX_LEVELS)) || (lvl_reg >= mip_count_reg);

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (lvl_bad)
            begin
                out_off_reg   <= 48'd0;
                out_span_reg  <= 48'd0;
                out_row_reg   <= 32'd0;
                out_slice_reg <= 48'd0;
                out_err_reg   <= 1'b1;
            end
            else
            begin
                out_off_reg   <= off_reg;
                out_span_reg  <= span_reg;
                out_row_reg   <= 32'(row_reg);
                out_slice_reg <= 48'(slice_reg);
                out_err_reg   <= ovf_reg;
            end
        end
    end

    assign stat.lvl_bad  = lvl_bad;
    assign stat.m_done   = (m_reg == lvl_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign byte_offset = out_off_reg;
    assign span_bytes  = out_span_reg;
    assign row_pitch   = out_row_reg;
    assign slice_pitch = out_slice_reg;
    assign error       = out_err_reg;

endmodule

>>> hdl/mip_chain_subresource_address.sv
`timescale 1ns / 1ps
// a request is accepted only while idle, and no new request is taken until its word
// enters the output register; the walk over earlier mip levels runs through the single
//   shared 32x16 multiplier (8 steps per level, 9 for the region terms)
// the output register lets the next word enter while a result still waits downstream
// reset: asynchronous active low; config returns to its defaults, no result pending
// ----------------------------------------------------------------------------
// mip_chain_subresource_address
// byte offset, span, row pitch and slice pitch of a region in a mip-major texture
// ----------------------------------------------------------------------------
module mip_chain_subresource_address
#(
    parameter int unsigned MAX_LEVELS = mcsa_pkg::MAX_LEVELS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mcsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcsa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [3:0]                          level,
    input  logic [13:0]                         origin_x,
    input  logic [13:0]                         origin_y,
    input  logic [10:0]                         origin_z,
    input  logic [14:0]                         extent_w,
    input  logic [14:0]                         extent_h,
    input  logic [11:0]                         extent_d,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [47:0]                         byte_offset,
    output logic [47:0]                         span_bytes,
    output logic [31:0]                         row_pitch,
    output logic [47:0]                         slice_pitch,
    output logic                                error
);

    mcsa_pkg::cmd_t  cmd;
    mcsa_pkg::stat_t stat;

    mcsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcsa_datapath
    #(
        .MAX_LEVELS (MAX_LEVELS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .level       (level),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .origin_z    (origin_z),
        .extent_w    (extent_w),
        .extent_h    (extent_h),
        .extent_d    (extent_d),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .byte_offset (byte_offset),
        .span_bytes  (span_bytes),
        .row_pitch   (row_pitch),
        .slice_pitch (slice_pitch),
        .error       (error)
    );

endmodule

>>> hdl/mcsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsa_checker
// port-level checks of the address unit, bound to the top level
// ----------------------------------------------------------------------------
`include "mip_chain_subresource_address_assert.svh"

module mcsa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [47:0] byte_offset,
    input logic [47:0] span_bytes,
    input logic [31:0] row_pitch,
    input logic [47:0] slice_pitch,
    input logic        error
);

    // a held word keeps its offset, span and error flag
    `MCSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(byte_offset) && $stable(span_bytes) && $stable(error))

    // one word at a time: busy right after an accept
    `MCSA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // pitches stay within the widths the datapath carries
    `MCSA_ASSERT_IMPL(a_row_range, clk, rst_n, out_valid, row_pitch[31:mcsa_pkg::ROW_W] == '0)
    `MCSA_ASSERT_IMPL(a_slice_range, clk, rst_n, out_valid, slice_pitch[47:mcsa_pkg::SLICE_W] == '0)

endmodule

bind mip_chain_subresource_address mcsa_checker u_mcsa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_offset (byte_offset),
    .span_bytes  (span_bytes),
    .row_pitch   (row_pitch),
    .slice_pitch (slice_pitch),
    .error       (error)
);

>>> tb/mip_chain_subresource_address_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_subresource_address_test
// region requests to the mip chain address unit under several texture setups,
// each accepted request scored against a local calculation of offset, span,
// row pitch, slice pitch and error flag, with random idle and stall bursts
// ----------------------------------------------------------------------------
module mip_chain_subresource_address_test;

    localparam logic [63:0] CAP48          = 64'hFFFF_FFFF_FFFF;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_PHASES  = 12;
    localparam int          PHASE_ITEMS    = 80;

    typedef struct packed {
        logic [3:0]  level;
        logic [13:0] origin_x;
        logic [13:0] origin_y;
        logic [10:0] origin_z;
        logic [14:0] extent_w;
        logic [14:0] extent_h;
        logic [11:0] extent_d;
    } region_t;

    typedef struct packed {
        logic [47:0] byte_offset;
        logic [47:0] span_bytes;
        logic [31:0] row_pitch;
        logic [47:0] slice_pitch;
        logic        error;
    } addr_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [mcsa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mcsa_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [3:0]                       level = '0;
    logic [13:0]                      origin_x = '0;
    logic [13:0]                      origin_y = '0;
    logic [10:0]                      origin_z = '0;
    logic [14:0]                      extent_w = '0;
    logic [14:0]                      extent_h = '0;
    logic [11:0]                      extent_d = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [47:0]                      byte_offset;
    logic [47:0]                      span_bytes;
    logic [31:0]                      row_pitch;
    logic [47:0]                      slice_pitch;
    logic                             error;

    // local copy of the texture setup
    logic [14:0] tex_width = 15'd1;
    logic [14:0] tex_height = 15'd1;
    logic [11:0] tex_depth = 12'd1;
    logic [3:0]  tex_mips = 4'd1;
    logic        tex_volume = 1'b0;
    logic [4:0]  tex_texel = 5'd4;
    logic [4:0]  tex_samples = 5'd1;
    logic [3:0]  tex_align = 4'd0;

    region_t pending_regions[$];
    addr_t   expected_addrs[$];
    region_t next_region;
    addr_t   want_addr;

    logic in_sent = 1'b0;
    logic idle_on = 1'b1;
    logic drain_hold = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   failures = 0;

    mip_chain_subresource_address dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level       (level),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .origin_z    (origin_z),
        .extent_w    (extent_w),
        .extent_h    (extent_h),
        .extent_d    (extent_d),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_offset (byte_offset),
        .span_bytes  (span_bytes),
        .row_pitch   (row_pitch),
        .slice_pitch (slice_pitch),
        .error       (error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] at_least_one(input logic [63:0] v);
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic logic [63:0] dim_at(input logic [63:0] base, input int lvl);
        return at_least_one(at_least_one(base) >> lvl);
    endfunction

    function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b,
                                            inout logic ovf);
        if (a == 0 || b == 0)
            return 64'd0;
        if (a > CAP48 || b > CAP48 / a)
        begin
            ovf = 1'b1;
            return CAP48;
        end
        return a * b;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            inout logic ovf);
        logic [63:0] s;
        s = a + b;
        if (s > CAP48)
        begin
            ovf = 1'b1;
            return CAP48;
        end
        return s;
    endfunction

    function automatic logic [63:0] row_bytes_at(input int lvl);
        logic [63:0] raw;
        logic [63:0] mask;
        raw = dim_at(64'(tex_width), lvl) * 64'(tex_texel) * 64'(tex_samples);
        mask = (64'd1 << tex_align) - 64'd1;
        return (raw + mask) & ~mask;
    endfunction

    // each product is taken on its own so the overflow flag passes through in order
    function automatic addr_t predict_address(input region_t r);
        addr_t       a;
        logic        ovf;
        logic [63:0] off, row, slice, span, sp, cnt, part, ew, eh, ed;
        int          m;
        a = '0;
        ovf = 1'b0;
        off = 64'd0;
        if (r.level >= tex_mips || r.level >= mcsa_pkg::MAX_LEVELS_DEF)
        begin
            a.error = 1'b1;
            return a;
        end
        ew = at_least_one(64'(r.extent_w));
        eh = at_least_one(64'(r.extent_h));
        ed = at_least_one(64'(r.extent_d));
        // every earlier level, all of its slices or layers
        for (m = 0; m < int'(r.level); m++)
        begin
            sp = sat_mul(row_bytes_at(m), dim_at(64'(tex_height), m), ovf);
            cnt = tex_volume ? dim_at(64'(tex_depth), m) : at_least_one(64'(tex_depth));
            part = sat_mul(sp, cnt, ovf);
            off = sat_add(off, part, ovf);
        end
        row = row_bytes_at(int'(r.level));
        slice = sat_mul(row, dim_at(64'(tex_height), int'(r.level)), ovf);
        part = sat_mul(64'(r.origin_z), slice, ovf);
        off = sat_add(off, part, ovf);
        part = sat_mul(64'(r.origin_y), row, ovf);
        off = sat_add(off, part, ovf);
        part = sat_mul(64'(r.origin_x), 64'(tex_texel), ovf);
        off = sat_add(off, part, ovf);
        span = sat_mul(ed - 64'd1, slice, ovf);
        part = sat_mul(eh - 64'd1, row, ovf);
        span = sat_add(span, part, ovf);
        part = sat_mul(ew, 64'(tex_texel), ovf);
        span = sat_add(span, part, ovf);
        a.byte_offset = off[47:0];
        a.span_bytes = span[47:0];
        a.row_pitch = row[31:0];
        a.slice_pitch = slice[47:0];
        a.error = ovf;
        return a;
    endfunction

    // mostly in-range levels and regions inside the level, some raw noise
    function automatic region_t random_region();
        region_t     r;
        logic [63:0] w, h, d;
        if (tex_mips != 0 && $urandom_range(0, 9) != 0)
            r.level = 4'($urandom_range(0, int'(tex_mips) - 1));
        else
            r.level = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0)
        begin
            r.origin_x = 14'($urandom);
            r.origin_y = 14'($urandom);
            r.origin_z = 11'($urandom);
            r.extent_w = 15'($urandom);
            r.extent_h = 15'($urandom);
            r.extent_d = 12'($urandom);
        end
        else
        begin
            w = dim_at(64'(tex_width), int'(r.level));
            h = dim_at(64'(tex_height), int'(r.level));
            d = tex_volume ? dim_at(64'(tex_depth), int'(r.level))
                           : at_least_one(64'(tex_depth));
            r.origin_x = 14'($urandom_range(0, int'(w) - 1));
            r.origin_y = 14'($urandom_range(0, int'(h) - 1));
            r.origin_z = 11'($urandom_range(0, int'(d) - 1));
            r.extent_w = 15'($urandom_range(1, int'(w)));
            r.extent_h = 15'($urandom_range(1, int'(h)));
            r.extent_d = 12'($urandom_range(1, int'(d)));
        end
        return r;
    endfunction

    task automatic queue_region(input int lvl, input int ox, input int oy, input int oz,
                                input int ew, input int eh, input int ed);
        pending_regions.push_back({4'(lvl), 14'(ox), 14'(oy), 11'(oz),
                                   15'(ew), 15'(eh), 12'(ed)});
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input mcsa_pkg::reg_index_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= mcsa_pkg::CFG_DATA_W'(value);
        @(negedge clk);
    endtask

    // called at a falling edge while nothing is in flight
    task automatic set_texture(input int w, input int h, input int d, input int mips,
                               input int vol, input int texel, input int samples,
                               input int align);
        tex_width = 15'(w);
        tex_height = 15'(h);
        tex_depth = 12'(d);
        tex_mips = 4'(mips);
        tex_volume = 1'(vol);
        tex_texel = 5'(texel);
        tex_samples = 5'(samples);
        tex_align = 4'(align);
        write_reg(mcsa_pkg::REG_BASE_WIDTH, w);
        write_reg(mcsa_pkg::REG_BASE_HEIGHT, h);
        write_reg(mcsa_pkg::REG_BASE_DEPTH, d);
        write_reg(mcsa_pkg::REG_MIP_COUNT, mips);
        write_reg(mcsa_pkg::REG_VOLUME_MODE, vol);
        write_reg(mcsa_pkg::REG_TEXEL_BYTES, texel);
        write_reg(mcsa_pkg::REG_SAMPLE_COUNT, samples);
        write_reg(mcsa_pkg::REG_ROW_ALIGN_LOG2, align);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // returns at a falling edge once every word is sent and answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_regions.size() != 0 || in_valid || expected_addrs.size() != 0);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (in_sent && idle_on)
        begin
            if ($urandom_range(0, 9) == 0)
                gap_left = $urandom_range(1, 19);
            else if ($urandom_range(0, 79) == 0)
                drain_hold = 1'b1;
        end
        if (!in_valid || in_sent)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (drain_hold && expected_addrs.size() != 0)
                in_valid <= 1'b0;
            else if (pending_regions.size() != 0)
            begin
                drain_hold = 1'b0;
                next_region = pending_regions.pop_front();
                level <= next_region.level;
                origin_x <= next_region.origin_x;
                origin_y <= next_region.origin_y;
                origin_z <= next_region.origin_z;
                extent_w <= next_region.extent_w;
                extent_h <= next_region.extent_h;
                extent_d <= next_region.extent_d;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 11) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 18);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_sent <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_addrs.push_back(predict_address({level, origin_x, origin_y,
                    origin_z, extent_w, extent_h, extent_d}));
            if (out_valid && !out_stall)
            begin
                if (expected_addrs.size() == 0)
                begin
                    $error("result word with no request pending");
                    failures++;
                end
                else
                begin
                    want_addr = expected_addrs.pop_front();
                    check_field("byte_offset", 64'(want_addr.byte_offset), 64'(byte_offset));
                    check_field("span_bytes", 64'(want_addr.span_bytes), 64'(span_bytes));
                    check_field("row_pitch", 64'(want_addr.row_pitch), 64'(row_pitch));
                    check_field("slice_pitch", 64'(want_addr.slice_pitch), 64'(slice_pitch));
                    check_field("error", 64'(want_addr.error), 64'(error));
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int  ph;
        int  w, h, d, texel, samples, align;
        bit  extreme;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setup: zero extents, widest fields, levels past the mip count
        queue_region(0, 0, 0, 0, 0, 0, 0);
        queue_region(0, 16383, 16383, 2047, 32767, 32767, 4095);
        queue_region(1, 5, 5, 5, 1, 1, 1);
        queue_region(15, 0, 0, 0, 1, 1, 1);
        wait_drained();

        // large layered texture with a full mip chain
        set_texture(16384, 16384, 2048, 15, 0, 16, 16, 12);
        queue_region(0, 0, 0, 0, 1, 1, 1);
        queue_region(14, 16383, 16383, 2047, 32767, 32767, 4095);
        queue_region(14, 0, 0, 0, 0, 0, 0);
        queue_region(15, 0, 0, 0, 1, 1, 1);
        queue_region(7, 100, 50, 3, 10, 10, 2);
        wait_drained();

        // volume that halves per level
        set_texture(1000, 600, 300, 11, 1, 3, 1, 8);
        queue_region(0, 1, 2, 3, 4, 5, 6);
        queue_region(5, 7, 3, 2, 20, 10, 4);
        queue_region(10, 0, 0, 0, 1, 1, 1);
        queue_region(11, 0, 0, 0, 1, 1, 1);
        wait_drained();

        // zero base sizes count as one, zero samples give a zero pitch
        set_texture(0, 0, 0, 15, 1, 5, 0, 0);
        queue_region(0, 9, 9, 9, 3, 3, 3);
        queue_region(3, 0, 0, 0, 0, 0, 0);
        queue_region(14, 16383, 1, 1, 2, 2, 2);
        wait_drained();

        // no mip levels at all
        set_texture(7, 3, 5, 0, 0, 4, 1, 3);
        queue_region(0, 0, 0, 0, 1, 1, 1);
        queue_region(2, 1, 1, 1, 1, 1, 1);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            extreme = (ph % 4 == 0);
            w = extreme ? ($urandom_range(0, 1) ? 16384 : 1)
                        : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16384 : 200);
            h = extreme ? ($urandom_range(0, 1) ? 16384 : 1)
                        : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16384 : 200);
            d = extreme ? ($urandom_range(0, 1) ? 2048 : 1)
                        : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 2048 : 40);
            texel = extreme ? ($urandom_range(0, 1) ? 16 : 1) : $urandom_range(1, 16);
            samples = extreme ? ($urandom_range(0, 1) ? 16 : 1) : (1 << $urandom_range(0, 4));
            align = extreme ? ($urandom_range(0, 1) ? 12 : 0) : $urandom_range(0, 12);
            // one setup with a zero texel size
            if (ph == 7)
                texel = 0;
            set_texture(w, h, d, $urandom_range(1, 15), $urandom_range(0, 1),
                        texel, samples, align);
            // quiet handshakes in some phases and all through the last ones
            idle_on = (ph < RANDOM_PHASES - 2) && (ph % 3 != 2);
            repeat (PHASE_ITEMS) pending_regions.push_back(random_region());
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
